### design/srng_pkg.sv
// ----------------------------------------------------------------------------
// srng_pkg - shared definitions for the shuffled minimal standard generator
// Constants of the multiplicative generator, table geometry and the request
// type that the sequencer sends to the shuffle table.
// ----------------------------------------------------------------------------
`default_nettype none

package srng_pkg;

    localparam int WORD_W      = 31;
    localparam int MULT_W      = 15;
    localparam int PROD_W      = WORD_W + MULT_W;
    localparam int TABLE_DEPTH = 32;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int SEED_STEPS  = TABLE_DEPTH + 8;
    localparam int CNT_W       = $clog2(SEED_STEPS);

    localparam logic [MULT_W-1:0] MS_MULT = MULT_W'(16807);
    localparam logic [WORD_W-1:0] MS_MOD  = {WORD_W{1'b1}};

    typedef enum logic {
        CMD_DRAW = 1'b0,
        CMD_SEED = 1'b1
    } cmd_t;

    typedef struct packed {
        logic              wr_en;
        logic [TBL_AW-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              rd_en;
        logic [TBL_AW-1:0] rd_addr;
    } tbl_req_t;

endpackage

`default_nettype wire

### design/srng_mulmod.sv
// ----------------------------------------------------------------------------
// srng_mulmod - shared modular multiply unit
// Computes 16807*x mod (2^31-1) in registered steps: multiply into a product
// register, then fold the high part onto the low part with one conditional subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module srng_mulmod
    import srng_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] x,
    output logic                   done,
    output logic [WORD_W-1:0]      y
);

    logic [PROD_W-1:0] prod_reg;
    logic              prod_valid_reg;
    logic              done_reg;
    logic [WORD_W-1:0] y_reg;
    logic [WORD_W:0]   fold_sum;
    logic [WORD_W-1:0] y_next;

    always_comb begin
        fold_sum = {1'b0, prod_reg[WORD_W-1:0]} + (WORD_W+1)'(prod_reg[PROD_W-1:WORD_W]);
        if (fold_sum >= {1'b0, MS_MOD}) begin
            y_next = WORD_W'(fold_sum - {1'b0, MS_MOD});
        end else begin
            y_next = fold_sum[WORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end else begin
            prod_valid_reg <= start;
            done_reg       <= prod_valid_reg;
        end
        if (start) begin
            prod_reg <= {{MULT_W{1'b0}}, x} * {{WORD_W{1'b0}}, MS_MULT};
        end
        if (prod_valid_reg) begin
            y_reg <= y_next;
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

`default_nettype wire

### design/srng_table.sv
// ----------------------------------------------------------------------------
// srng_table - shuffle table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srng_table
    import srng_pkg::*;
(
    input  wire logic              aclk,
    input  wire tbl_req_t          req,
    output logic [WORD_W-1:0]      rd_data
);

    logic [WORD_W-1:0] mem [TABLE_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/shuffled_minimal_standard_rng.sv
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_rng - minimal standard generator with shuffle
// Multiplier 16807 modulo 2^31-1 behind a 32-entry shuffle table.
// ----------------------------------------------------------------------------
// Each input item is a draw (tuser 0) or a reseed from tdata (tuser 1) and
// gives one 31-bit result; divide it by 2147483647 for a deviate in (0,1).
// One modular multiply unit does every generator step (start, multiply, fold).
// A draw on a seeded generator steps the generator and reads the table, then
// waits for a free output register; a reseed, or the first draw after reset,
// first runs 40 steps. The block takes no new item until the result is in the
// output register.
`default_nettype none

module shuffled_minimal_standard_rng
    import srng_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [30:0] seed_value
    input  wire logic [0:0]  s_tuser,   // [0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [30:0] random_value
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_DRAW,
        ST_OUT
    } fsm_t;

    fsm_t              fsm_reg;
    logic [WORD_W-1:0] state_reg;
    logic [WORD_W-1:0] last_reg;
    logic [WORD_W-1:0] out_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              mul_start_reg;
    logic              m_tvalid_reg;

    logic              mul_done;
    logic [WORD_W-1:0] mul_y;
    logic [WORD_W-1:0] rd_data;
    tbl_req_t          tbl_req;
    logic [WORD_W-1:0] seed_raw;
    logic [WORD_W-1:0] seed_fix;
    logic              out_free;
    logic [TBL_AW-1:0] slot;

    srng_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .x       (state_reg),
        .done    (mul_done),
        .y       (mul_y)
    );

    srng_table u_table (
        .aclk    (aclk),
        .req     (tbl_req),
        .rd_data (rd_data)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign slot     = last_reg[WORD_W-1 -: TBL_AW];

    always_comb begin
        seed_raw = (cmd_t'(s_tuser[0]) == CMD_SEED) ? s_tdata[WORD_W-1:0] : WORD_W'(1);
        if (seed_raw == '0 || seed_raw == MS_MOD) begin
            seed_fix = WORD_W'(1);
        end else begin
            seed_fix = seed_raw;
        end
    end

    always_comb begin
        tbl_req.rd_en   = mul_start_reg && (fsm_reg == ST_DRAW);
        tbl_req.rd_addr = slot;
        tbl_req.wr_en   = 1'b0;
        tbl_req.wr_addr = cnt_reg[TBL_AW-1:0];
        tbl_req.wr_data = mul_y;
        if (fsm_reg == ST_STEP && mul_done && cnt_reg < CNT_W'(TABLE_DEPTH)) begin
            tbl_req.wr_en = 1'b1;
        end else if (fsm_reg == ST_OUT && out_free) begin
            tbl_req.wr_en   = 1'b1;
            tbl_req.wr_addr = slot;
            tbl_req.wr_data = state_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg       <= ST_IDLE;
            state_reg     <= '0;
            last_reg      <= '0;
            cnt_reg       <= '0;
            mul_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            mul_start_reg <= 1'b0;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (fsm_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        mul_start_reg <= 1'b1;
                        if (cmd_t'(s_tuser[0]) == CMD_SEED || last_reg == '0) begin
                            state_reg <= seed_fix;
                            cnt_reg   <= CNT_W'(SEED_STEPS - 1);
                            fsm_reg   <= ST_STEP;
                        end else begin
                            fsm_reg <= ST_DRAW;
                        end
                    end
                end
                ST_STEP: begin
                    if (mul_done) begin
                        state_reg     <= mul_y;
                        mul_start_reg <= 1'b1;
                        if (cnt_reg == '0) begin
                            last_reg <= mul_y;
                            fsm_reg  <= ST_DRAW;
                        end else begin
                            cnt_reg <= cnt_reg - CNT_W'(1);
                        end
                    end
                end
                ST_DRAW: begin
                    if (mul_done) begin
                        state_reg <= mul_y;
                        fsm_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        out_reg      <= rd_data;
                        last_reg     <= rd_data;
                        m_tvalid_reg <= 1'b1;
                        fsm_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    fsm_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (fsm_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_reg};

    a_done_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (fsm_reg == ST_STEP || fsm_reg == ST_DRAW))
        else $error("multiply result outside a stepping state");

    a_state_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg == ST_DRAW || fsm_reg == ST_OUT) |-> state_reg != '0)
        else $error("generator state zero while drawing");

    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> (out_reg != '0 && out_reg != MS_MOD && last_reg == out_reg))
        else $error("result out of range or not kept as last output");

endmodule

`default_nettype wire
